/* rtl/core/tip_hub_loss_factor_unit_defines.svh */
// assertion macros shared by the loss factor unit rtl
// no dependencies; include by bare file name
`ifndef TIP_HUB_LOSS_FACTOR_UNIT_DEFINES_SVH
`define TIP_HUB_LOSS_FACTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define THLF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define THLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/thlf_pkg.sv */
// shared types, constants and stage counts of the loss factor unit
// no dependencies
package thlf_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int RAD_W         = 24;
  localparam int SIN_W         = 18;
  localparam int BN_W          = 5;
  localparam int OUT_W         = FRAC_BITS + 1;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_BLADE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUB   = 2'd2;

  localparam int DEN_W  = 42;
  localparam int DIV_W  = DEN_W + 5;
  localparam int FAC_W  = 32;
  localparam logic [FAC_W-1:0] ONE31 = 32'h8000_0000;
  localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;

  localparam int Q_DEPTH = 4;

  localparam int DIV_STEPS  = 31;
  localparam int EXP_TERMS  = 14;
  localparam int SQ_STEPS   = 5;
  localparam int SQRT_STEPS = 32;
  localparam int ASIN_TERMS = 40;
  localparam int PF_LAT = DIV_STEPS + 2 * EXP_TERMS + SQ_STEPS + SQRT_STEPS + 1
                          + 3 * ASIN_TERMS + 1;

  typedef struct packed {
    logic             frc;
    logic             fval;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } pf_req_t;

  typedef struct packed {
    logic    bad;
    pf_req_t tip;
    pf_req_t hub;
  } q_entry_t;

endpackage

/* rtl/core/thlf_front.sv */
// front end: config registers, input word register and lane setup
// depends on thlf_pkg
module thlf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [thlf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [thlf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [thlf_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic                                full_i,
  output logic                                push_o,
  output thlf_pkg::q_entry_t                  entry_o
);
  import thlf_pkg::*;

  localparam int NUM_W = BN_W + RAD_W + FRAC_BITS;
  localparam int CMP_W = (NUM_W > DIV_W) ? NUM_W : DIV_W;

  logic [BN_W-1:0]  blade_q;
  logic [RAD_W-1:0] tip_q;
  logic [RAD_W-1:0] hub_q;
  logic             vld_q;
  q_entry_t         ent_q;
  q_entry_t         ent_d;
  logic [RAD_W-1:0] r;
  logic [SIN_W-1:0] s;
  logic             accept;

  function automatic pf_req_t mk_req(input logic frc1, input logic frc0,
                                     input logic [RAD_W-1:0] diff,
                                     input logic [RAD_W-1:0] base,
                                     input logic [SIN_W-2:0] sp,
                                     input logic [BN_W-1:0] bn);
    logic [BN_W+RAD_W-1:0] prod;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    logic                  sat;
    pf_req_t               rq;
    prod    = (BN_W+RAD_W)'(bn) * (BN_W+RAD_W)'(diff);
    num     = NUM_W'(prod) << FRAC_BITS;
    den     = (DEN_W'(base) * DEN_W'(sp)) << 1;
    // quotient of 32 or more saturates the factor to one, unless frc0 forces zero
    sat     = CMP_W'(num) >= (CMP_W'(den) << 5);
    rq.frc  = frc1 | frc0 | sat;
    rq.fval = frc1 | (!frc0 & sat);
    rq.num  = DIV_W'(num);
    rq.den  = den;
    return rq;
  endfunction

  assign r = s_tdata_i[RAD_W-1:0];
  assign s = s_tdata_i[RAD_W+SIN_W-1:RAD_W];

  always_comb begin
    ent_d.bad = s[SIN_W-1] || (s == '0);
    ent_d.tip = mk_req(r == '0, tip_q <= r, tip_q - r, r, s[SIN_W-2:0], blade_q);
    ent_d.hub = mk_req(hub_q == '0, r <= hub_q, r - hub_q, hub_q, s[SIN_W-2:0], blade_q);
  end

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = !vld_q || !full_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign push_o      = vld_q && !full_i;
  assign entry_o     = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blade_q <= BN_W'(3);
      tip_q   <= RAD_W'(65536);
      hub_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLADE: blade_q <= cfg_data_i[BN_W-1:0];
        CFG_TIP:   tip_q   <= cfg_data_i[RAD_W-1:0];
        CFG_HUB:   hub_q   <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= ent_d;
    end
  end

endmodule

/* rtl/core/thlf_queue.sv */
// short queue between front end and back end
// depends on thlf_pkg and the assertion macro header
`include "tip_hub_loss_factor_unit_defines.svh"
module thlf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  thlf_pkg::q_entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output thlf_pkg::q_entry_t data_o
);
  import thlf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t           mem_q [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = cnt_q == CNT_W'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `THLF_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `THLF_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `THLF_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count did not rise on push")
  `THLF_ASSERT_NOW(a_ptr_gap, clk_i, rst_ni, 1'b1, (wr_ptr_q - rd_ptr_q) == cnt_q[PTR_W-1:0], "pointers and count disagree")

endmodule

/* rtl/core/thlf_pf.sv */
// one partial loss factor lane: divide, exp series, squarings, isqrt, asin series
// depends on thlf_pkg
module thlf_pf (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  thlf_pkg::pf_req_t             req_i,
  output logic [thlf_pkg::FAC_W-1:0]    fac_o
);
  import thlf_pkg::*;

  localparam int Y_W  = 31;
  localparam int SR_W = 63;

  // forced result travels beside the datapath
  logic [PF_LAT-1:0] frc_q;
  logic [PF_LAT-1:0] fval_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frc_q  <= {frc_q[PF_LAT-2:0], req_i.frc};
      fval_q <= {fval_q[PF_LAT-2:0], req_i.fval};
    end
  end

  // restoring division, one quotient bit per stage
  logic [DIV_W-1:0] dv_rem_q [DIV_STEPS];
  logic [DEN_W-1:0] dv_den_q [DIV_STEPS];
  logic [Y_W-1:0]   dv_y_q   [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int SH = (i < 5) ? 4 - i : 0;
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] rem_sh;
    logic [DIV_W-1:0] dsor;
    logic [DEN_W-1:0] den_in;
    logic [Y_W-1:0]   y_in;
    logic             ge;
    if (i == 0) begin : g_first
      assign rem_in = req_i.num;
      assign den_in = req_i.den;
      assign y_in   = '0;
    end else begin : g_next
      assign rem_in = dv_rem_q[i-1];
      assign den_in = dv_den_q[i-1];
      assign y_in   = dv_y_q[i-1];
    end
    // integer part bits compare against the shifted divisor, fraction bits shift the rest
    assign rem_sh = (i < 5) ? rem_in : (rem_in << 1);
    assign dsor   = DIV_W'(den_in) << SH;
    assign ge     = rem_sh >= dsor;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[i] <= ge ? (rem_sh - dsor) : rem_sh;
        dv_den_q[i] <= den_in;
        dv_y_q[i]   <= {y_in[Y_W-2:0], ge};
      end
    end
  end

  // exp(-y) taylor series, two stages per term
  logic [30:0]        exa_p_q   [EXP_TERMS];
  logic signed [33:0] exa_sum_q [EXP_TERMS];
  logic [Y_W-1:0]     exa_y_q   [EXP_TERMS];
  logic [FAC_W-1:0]   ex_term_q [EXP_TERMS];
  logic signed [33:0] ex_sum_q  [EXP_TERMS];
  logic [Y_W-1:0]     ex_y_q    [EXP_TERMS];

  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_exp
    localparam int K = g + 1;
    localparam logic [35:0] MK = 36'(((64'd1 << 35) + 64'(K) - 64'd1) / 64'(K));
    logic [FAC_W-1:0]   term_in;
    logic signed [33:0] sum_in;
    logic [Y_W-1:0]     y_in;
    logic [62:0]        pa;
    logic [66:0]        pb;
    logic [FAC_W-1:0]   tk;
    if (g == 0) begin : g_first
      assign term_in = ONE31;
      assign sum_in  = $signed({2'b00, ONE31});
      assign y_in    = dv_y_q[DIV_STEPS-1];
    end else begin : g_next
      assign term_in = ex_term_q[g-1];
      assign sum_in  = ex_sum_q[g-1];
      assign y_in    = ex_y_q[g-1];
    end
    assign pa = 63'(term_in) * 63'(y_in);
    // exact division by k through a reciprocal, the quotient stays below 2^31
    assign pb = 67'(exa_p_q[g]) * 67'(MK);
    assign tk = pb[66:35];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        exa_p_q[g]   <= pa[61:31];
        exa_sum_q[g] <= sum_in;
        exa_y_q[g]   <= y_in;
        ex_term_q[g] <= tk;
        ex_sum_q[g]  <= (K % 2 == 1) ? (exa_sum_q[g] - $signed({2'b00, tk}))
                                     : (exa_sum_q[g] + $signed({2'b00, tk}));
        ex_y_q[g]    <= exa_y_q[g];
      end
    end
  end

  // clamp then square five times
  logic [FAC_W-1:0] sq_x_q [SQ_STEPS];
  logic [FAC_W-1:0] ex_clamp;
  logic signed [33:0] ex_last;

  assign ex_last  = ex_sum_q[EXP_TERMS-1];
  assign ex_clamp = ex_last[33] ? '0 :
                    (ex_last[32:0] > 33'(ONE31)) ? ONE31 : ex_last[31:0];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    logic [FAC_W-1:0] x_in;
    logic [63:0]      sqp;
    if (i == 0) begin : g_first
      assign x_in = ex_clamp;
    end else begin : g_next
      assign x_in = sq_x_q[i-1];
    end
    assign sqp = 64'(x_in) * 64'(x_in);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_x_q[i] <= sqp[62:31];
      end
    end
  end

  // integer square root of (1 - x) << 30, one result bit per stage
  logic [SR_W-1:0] sr_n_q   [SQRT_STEPS];
  logic [SR_W-1:0] sr_res_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [SR_W-1:0] BIT = SR_W'(1) << (62 - 2 * i);
    logic [SR_W-1:0] n_in;
    logic [SR_W-1:0] res_in;
    logic [SR_W-1:0] trial;
    logic            ge;
    if (i == 0) begin : g_first
      assign n_in   = SR_W'(ONE31 - sq_x_q[SQ_STEPS-1]) << 30;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = sr_n_q[i-1];
      assign res_in = sr_res_q[i-1];
    end
    assign trial = res_in + BIT;
    assign ge    = n_in >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_n_q[i]   <= ge ? (n_in - trial) : n_in;
        sr_res_q[i] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
      end
    end
  end

  // z and z squared
  logic [30:0] z;
  logic [61:0] zz;
  logic [30:0] z_q;
  logic [30:0] z2_q;

  assign z  = sr_res_q[SQRT_STEPS-1][30:0];
  assign zz = 62'(z) * 62'(z);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q  <= z;
      z2_q <= zz[61:31];
    end
  end

  // asin series, three stages per term
  logic [30:0]      aa_t_q    [ASIN_TERMS];
  logic [FAC_W-1:0] aa_asn_q  [ASIN_TERMS];
  logic [30:0]      aa_z2_q   [ASIN_TERMS];
  logic [59:0]      ab_lo_q   [ASIN_TERMS];
  logic [58:0]      ab_hi_q   [ASIN_TERMS];
  logic [30:0]      ab_t_q    [ASIN_TERMS];
  logic [FAC_W-1:0] ab_asn_q  [ASIN_TERMS];
  logic [30:0]      ab_z2_q   [ASIN_TERMS];
  logic [30:0]      ac_term_q [ASIN_TERMS];
  logic [FAC_W-1:0] ac_asn_q  [ASIN_TERMS];
  logic [30:0]      ac_z2_q   [ASIN_TERMS];

  for (genvar g = 0; g < ASIN_TERMS; g++) begin : g_asin
    localparam longint unsigned CK = longint'((2 * g + 1) * (2 * g + 1));
    localparam longint unsigned DK = longint'((2 * g + 2) * (2 * g + 3));
    localparam longint unsigned MD = (64'd1 << 44) / DK;
    localparam logic [43:0] KM = 44'(CK * MD);
    logic [30:0]      term_in;
    logic [FAC_W-1:0] asn_in;
    logic [30:0]      z2_in;
    logic [61:0]      pa;
    logic [75:0]      psum;
    logic [30:0]      q0;
    logic [43:0]      xv;
    logic [43:0]      qd;
    logic [43:0]      rv;
    logic [30:0]      qv;
    if (g == 0) begin : g_first
      assign term_in = z_q;
      assign asn_in  = FAC_W'(z_q);
      assign z2_in   = z2_q;
    end else begin : g_next
      assign term_in = ac_term_q[g-1];
      assign asn_in  = ac_asn_q[g-1];
      assign z2_in   = ac_z2_q[g-1];
    end
    assign pa   = 62'(term_in) * 62'(z2_in);
    // quotient estimate from the reciprocal is low by at most one
    assign psum = {1'b0, ab_hi_q[g], 16'h0000} + 76'(ab_lo_q[g]);
    assign q0   = psum[74:44];
    assign xv   = 44'(ab_t_q[g]) * 44'(CK);
    assign qd   = 44'(q0) * 44'(DK);
    assign rv   = xv - qd;
    assign qv   = (rv >= 44'(DK)) ? (q0 + 1'b1) : q0;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        aa_t_q[g]    <= pa[61:31];
        aa_asn_q[g]  <= asn_in;
        aa_z2_q[g]   <= z2_in;
        ab_lo_q[g]   <= 60'(aa_t_q[g][15:0]) * 60'(KM);
        ab_hi_q[g]   <= 59'(aa_t_q[g][30:16]) * 59'(KM);
        ab_t_q[g]    <= aa_t_q[g];
        ab_asn_q[g]  <= aa_asn_q[g];
        ab_z2_q[g]   <= aa_z2_q[g];
        ac_term_q[g] <= qv;
        ac_asn_q[g]  <= ab_asn_q[g] + FAC_W'(qv);
        ac_z2_q[g]   <= ab_z2_q[g];
      end
    end
  end

  // scale by 4/pi with rounding, clamp to one
  logic [63:0]      fp;
  logic [33:0]      f34;
  logic [FAC_W-1:0] fac_q;

  assign fp  = 64'(ac_asn_q[ASIN_TERMS-1]) * 64'(FOUR_OVER_PI_Q30) + (64'd1 << 29);
  assign f34 = fp[63:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fac_q <= (f34 > 34'(ONE31)) ? ONE31 : f34[31:0];
    end
  end

  assign fac_o = frc_q[PF_LAT-1] ? (fval_q[PF_LAT-1] ? ONE31 : '0) : fac_q;

endmodule

/* rtl/core/thlf_back.sv */
// back end: two factor lanes, product, rounding, floor and output register
// depends on thlf_pkg and thlf_pf
module thlf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  thlf_pkg::q_entry_t            entry_i,
  output logic                          pop_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [thlf_pkg::OUT_W-1:0]    loss_o
);
  import thlf_pkg::*;

  localparam logic [32:0] RND     = 33'(1) << (30 - FRAC_BITS);
  localparam logic [32:0] ONE_Q   = 33'(1) << FRAC_BITS;
  localparam logic [32:0] FLOOR_Q = 33'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  logic              en;
  logic [PF_LAT-1:0] vld_q;
  logic [PF_LAT-1:0] bad_q;
  logic [FAC_W-1:0]  ftip;
  logic [FAC_W-1:0]  fhub;
  logic              c1_vld_q;
  logic              c1_bad_q;
  logic [63:0]       c1_prod_q;
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_q;
  logic [32:0]       rsum;
  logic [32:0]       res;
  logic [32:0]       res_fl;

  // whole back end advances together unless the output word is stuck
  assign en    = !out_vld_q || m_tready_i;
  assign pop_o = en && !empty_i;

  thlf_pf u_tip (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (entry_i.tip),
    .fac_o (ftip)
  );

  thlf_pf u_hub (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (entry_i.hub),
    .fac_o (fhub)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      c1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PF_LAT-2:0], !empty_i};
      c1_vld_q  <= vld_q[PF_LAT-1];
      out_vld_q <= c1_vld_q;
    end
  end

  assign rsum   = {1'b0, c1_prod_q[62:31]} + RND;
  assign res    = rsum >> (31 - FRAC_BITS);
  assign res_fl = (res < FLOOR_Q) ? FLOOR_Q : res;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_q     <= {bad_q[PF_LAT-2:0], entry_i.bad};
      c1_bad_q  <= bad_q[PF_LAT-1];
      c1_prod_q <= 64'(ftip) * 64'(fhub);
      out_q     <= c1_bad_q ? ONE_Q[OUT_W-1:0] : res_fl[OUT_W-1:0];
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign loss_o     = out_q;

endmodule

/* rtl/core/tip_hub_loss_factor_unit.sv */
// Prandtl tip and hub loss factor unit, one result word per input word.
// Takes and returns one word per clock while m_axis_tready is high; a word
// passes in order through the input register that takes it, a queue slot,
// the 218 stages of each factor lane, the product stage and the output
// register that holds the result word. The lane depth comes from the
// 31-step long division, the exp and asin series (two and three stages per
// term), the squarings and the 32-step square root. A stalled result word
// holds the whole back end; the queue and input register then fill and
// drop s_axis_tready. Depends on thlf_pkg and all thlf modules.
module tip_hub_loss_factor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [thlf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [thlf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] element_radius, [41:24] inflow_sine, [47:42] zero
  input  logic [thlf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [16:0] loss_factor_out, [23:17] zero
  output logic [thlf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import thlf_pkg::*;

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  q_entry_t         q_in;
  q_entry_t         q_out;
  logic [OUT_W-1:0] loss;

  // front end classifies the word and sets up both lane divisions
  thlf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .full_i      (q_full),
    .push_o      (q_push),
    .entry_o     (q_in)
  );

  // decouples the front end from the stall of the back end
  thlf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  // back end evaluates both factors and forms the rounded product
  thlf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .entry_i    (q_out),
    .pop_o      (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .loss_o     (loss)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_W)'(0), loss};

endmodule
